>>> src/jprr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the jerk-based pitch and roll rate estimator
package jprr_pkg;

	// field widths
	localparam int RATE_W  = 32;
	localparam int ACCEL_W = 24;
	localparam int TIME_W  = 64;
	localparam int GAIN_W  = 20;
	localparam int ALPHA_W = 17;
	localparam int LIMIT_W = 31;
	localparam int IVAL_W  = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;

	// shared multiplier operand and product widths
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// jerk quotient width and the divider step counter
	localparam int JERK_W = 44;
	localparam int JERK_HALF_W = JERK_W / 2;
	localparam int DIV_CNT_W = $clog2(JERK_W);

	localparam logic [MUL_W-1:0]   NS_PER_SEC = 32'd1000000000;
	localparam logic [JERK_W-1:0]  JERK_CAP   = 44'h800_0000_0000;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;

	// register reset values
	localparam logic [GAIN_W-1:0]  PITCH_GAIN_RST = 20'd2097;
	localparam logic [GAIN_W-1:0]  ROLL_GAIN_RST  = 20'd1573;
	localparam logic [ALPHA_W-1:0] ALPHA_RST      = 17'd9830;
	localparam logic [LIMIT_W-1:0] LIMIT_RST      = 31'd104858;
	localparam logic [IVAL_W-1:0]  MIN_IVAL_RST   = 32'd1000000;
	localparam logic [IVAL_W-1:0]  MAX_IVAL_RST   = 32'd100000000;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_GAIN = 3'd0,
		REG_ROLL_GAIN  = 3'd1,
		REG_ALPHA      = 3'd2,
		REG_LIMIT      = 3'd3,
		REG_MIN_IVAL   = 3'd4,
		REG_MAX_IVAL   = 3'd5
	} jprr_reg_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} jprr_div_sts_t;

endpackage

>>> src/jerk_based_pitch_roll_rate_estimator.sv
`timescale 1ns / 1ps
// top level: sample sequencer, estimator state and stream ports
//
// Samples enter on the s_ stream group and one result per sample leaves on
// the m_ stream group; configuration registers are written through cfg_wr_en,
// cfg_index and cfg_wdata; the user must write them only while no sample is in
// flight, as the block itself does not enforce it. A sample with a bad yaw
// rate or without a usable interval goes from the check state straight to the
// finish state, which loads the output register. A sample that updates the
// estimate runs both axes in turn through one 32x32 multiplier and one
// restoring divider that yields one quotient bit per cycle; each axis runs
// the 44-step jerk division once unless its jerk is already past the cap.
// s_tready is high only while the sequencer is idle, so one sample is in
// flight at a time. The result sits in an output register; a new sample is
// taken while that register still waits, and the sequencer holds its next
// result until the receiver has taken the previous one.
// Reset clears the estimator state, restores the register defaults and
// empties the output register.
module jerk_based_pitch_roll_rate_estimator
	import jprr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [143:0]         s_tdata,  // yaw_in, long_accel, lateral_accel, time_ns
	input  logic [2:0]           s_tuser,  // yaw_bad, long_bad, lat_bad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [95:0]          m_tdata,  // yaw_out, pitch_out, roll_out
	output logic                 m_tuser,  // valid_res
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_CHK   = 13'b0000000000010,
		ST_MUL1  = 13'b0000000000100,
		ST_OVF   = 13'b0000000001000,
		ST_DIV   = 13'b0000000010000,
		ST_MUL2  = 13'b0000000100000,
		ST_MUL3  = 13'b0000001000000,
		ST_RAW   = 13'b0000010000000,
		ST_MUL4  = 13'b0000100000000,
		ST_MUL5  = 13'b0001000000000,
		ST_FILT  = 13'b0010000000000,
		ST_CLAMP = 13'b0100000000000,
		ST_FIN   = 13'b1000000000000
	} state_t;

	state_t st_q;

	// configuration
	logic [GAIN_W-1:0]  pitch_gain_q;
	logic [GAIN_W-1:0]  roll_gain_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [IVAL_W-1:0]  min_ival_q;
	logic [IVAL_W-1:0]  max_ival_q;

	// latched sample
	logic [RATE_W-1:0]  yaw_q;
	logic               yaw_bad_q;
	logic [ACCEL_W-1:0] lon_q;
	logic [ACCEL_W-1:0] lat_q;
	logic [TIME_W-1:0]  time_q;

	// estimator state
	logic [ACCEL_W-1:0] prev_lon_q;
	logic [ACCEL_W-1:0] prev_lat_q;
	logic [TIME_W-1:0]  prev_time_q;
	logic               have_prev_q;
	logic [RATE_W-1:0]  filt_q [2];
	logic [RATE_W-1:0]  held_q [2];

	// per-sample working registers
	logic               axis_q;
	logic [ACCEL_W:0]   dmag_q [2];
	logic               dneg_q [2];
	logic [IVAL_W-1:0]  dt_q;
	logic [JERK_W-1:0]  jerk_q;
	logic [41:0]        acc_q;
	logic [LIMIT_W-1:0] raw_mag_q;
	logic               raw_neg_q;
	logic [47:0]        p1_q;

	// output register
	logic               m_tvalid_q;
	logic [95:0]        m_tdata_q;
	logic               m_tuser_q;

	// shared units
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  mul_p;
	logic               div_start;
	logic [JERK_W-1:0]  div_q;
	jprr_div_sts_t      div_sts;

	logic               in_acc;
	logic               out_free;
	logic [TIME_W-1:0]  dt_full;
	logic               upd_ok;
	logic [ACCEL_W:0]   dlon;
	logic [ACCEL_W:0]   dlat;
	logic [GAIN_W-1:0]  gain;
	logic [ALPHA_W-1:0] alpha_sat;
	logic [ALPHA_W-1:0] alpha_cmp;
	logic [RATE_W-1:0]  filt_cur;
	logic [RATE_W-1:0]  filt_mag;
	logic               ovf;
	logic [PROD_W-1:0]  raw_full;
	logic [51:0]        raw_mag_full;
	logic [49:0]        lp_t1;
	logic [49:0]        lp_t2;
	logic [49:0]        lp_sum;
	logic [49:0]        lp_sh;
	logic [RATE_W:0]    cl_v;
	logic [RATE_W:0]    cl_lim;
	logic [RATE_W-1:0]  cl_res;
	logic               held_ok [2];

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = st_q == ST_IDLE;

	assign dt_full = time_q - prev_time_q;
	assign upd_ok  = have_prev_q && (prev_time_q != '0)
		&& (dt_full > TIME_W'(min_ival_q)) && (dt_full < TIME_W'(max_ival_q));
	assign dlon = {lon_q[ACCEL_W-1], lon_q} - {prev_lon_q[ACCEL_W-1], prev_lon_q};
	assign dlat = {lat_q[ACCEL_W-1], lat_q} - {prev_lat_q[ACCEL_W-1], prev_lat_q};

	assign gain      = axis_q ? roll_gain_q : pitch_gain_q;
	assign alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_cmp = ALPHA_ONE - alpha_sat;
	assign filt_cur  = filt_q[axis_q];
	assign filt_mag  = filt_cur[RATE_W-1] ? (RATE_W'(0) - filt_cur) : filt_cur;

	assign ovf = {12'b0, mul_p[63:JERK_W]} >= dt_q;

	assign raw_full     = {22'b0, acc_q} + {mul_p[41:0], 22'b0};
	assign raw_mag_full = raw_full[63:12];

	assign lp_t1  = raw_neg_q ? (50'd0 - {2'b0, p1_q}) : {2'b0, p1_q};
	assign lp_t2  = filt_cur[RATE_W-1] ? (50'd0 - {2'b0, mul_p[47:0]}) : {2'b0, mul_p[47:0]};
	assign lp_sum = lp_t1 + lp_t2;
	assign lp_sh  = $unsigned($signed(lp_sum) >>> 16);

	assign cl_v   = {filt_cur[RATE_W-1], filt_cur};
	assign cl_lim = {2'b0, limit_q};
	always_comb begin
		if ($signed(cl_v) > $signed(cl_lim)) begin
			cl_res = {1'b0, limit_q};
		end else if ($signed(cl_v) < $signed((RATE_W + 1)'(0) - cl_lim)) begin
			cl_res = RATE_W'(0) - {1'b0, limit_q};
		end else begin
			cl_res = filt_cur;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_MUL1: begin
				mul_a = MUL_W'(dmag_q[axis_q]);
				mul_b = NS_PER_SEC;
			end
			ST_MUL2: begin
				mul_a = MUL_W'(gain);
				mul_b = MUL_W'(jerk_q[JERK_HALF_W-1:0]);
			end
			ST_MUL3: begin
				mul_a = MUL_W'(gain);
				mul_b = MUL_W'(jerk_q[JERK_W-1:JERK_HALF_W]);
			end
			ST_MUL4: begin
				mul_a = MUL_W'(alpha_sat);
				mul_b = MUL_W'(raw_mag_q);
			end
			ST_MUL5: begin
				mul_a = MUL_W'(alpha_cmp);
				mul_b = filt_mag;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (st_q == ST_OVF) && !ovf;

	jprr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	jprr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init ({12'b0, mul_p[63:JERK_W]}),
		.num      (mul_p[JERK_W-1:0]),
		.den      (dt_q),
		.quo      (div_q),
		.sts      (div_sts)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_gain_q <= PITCH_GAIN_RST;
			roll_gain_q  <= ROLL_GAIN_RST;
			alpha_q      <= ALPHA_RST;
			limit_q      <= LIMIT_RST;
			min_ival_q   <= MIN_IVAL_RST;
			max_ival_q   <= MAX_IVAL_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PITCH_GAIN: pitch_gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_ROLL_GAIN:  roll_gain_q  <= cfg_wdata[GAIN_W-1:0];
				REG_ALPHA:      alpha_q      <= cfg_wdata[ALPHA_W-1:0];
				REG_LIMIT:      limit_q      <= cfg_wdata[LIMIT_W-1:0];
				REG_MIN_IVAL:   min_ival_q   <= cfg_wdata[IVAL_W-1:0];
				REG_MAX_IVAL:   max_ival_q   <= cfg_wdata[IVAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			axis_q      <= 1'b0;
			have_prev_q <= 1'b0;
			prev_lon_q  <= '0;
			prev_lat_q  <= '0;
			prev_time_q <= '0;
			filt_q[0]   <= '0;
			filt_q[1]   <= '0;
			held_q[0]   <= '0;
			held_q[1]   <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if ((st_q == ST_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					axis_q <= 1'b0;
					if (yaw_bad_q) begin
						st_q <= ST_FIN;
					end else begin
						prev_lon_q  <= lon_q;
						prev_lat_q  <= lat_q;
						prev_time_q <= time_q;
						have_prev_q <= 1'b1;
						st_q        <= upd_ok ? ST_MUL1 : ST_FIN;
					end
				end
				ST_MUL1: st_q <= ST_OVF;
				ST_OVF:  st_q <= ovf ? ST_MUL2 : ST_DIV;
				ST_DIV: begin
					if (div_sts.done) begin
						st_q <= ST_MUL2;
					end
				end
				ST_MUL2: st_q <= ST_MUL3;
				ST_MUL3: st_q <= ST_RAW;
				ST_RAW:  st_q <= ST_MUL4;
				ST_MUL4: st_q <= ST_MUL5;
				ST_MUL5: st_q <= ST_FILT;
				ST_FILT: begin
					filt_q[axis_q] <= lp_sh[RATE_W-1:0];
					st_q           <= ST_CLAMP;
				end
				ST_CLAMP: begin
					held_q[axis_q] <= cl_res;
					if (!axis_q) begin
						axis_q <= 1'b1;
						st_q   <= ST_MUL1;
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			yaw_q     <= s_tdata[31:0];
			yaw_bad_q <= s_tuser[0];
			lon_q     <= s_tuser[1] ? '0 : s_tdata[55:32];
			lat_q     <= s_tuser[2] ? '0 : s_tdata[79:56];
			time_q    <= s_tdata[143:80];
		end
		if (st_q == ST_CHK) begin
			dmag_q[0] <= dlon[ACCEL_W] ? ((ACCEL_W + 1)'(0) - dlon) : dlon;
			dmag_q[1] <= dlat[ACCEL_W] ? ((ACCEL_W + 1)'(0) - dlat) : dlat;
			dneg_q[0] <= dlon[ACCEL_W];
			dneg_q[1] <= dlat[ACCEL_W];
			dt_q      <= dt_full[IVAL_W-1:0];
		end
		if ((st_q == ST_OVF) && ovf) begin
			jerk_q <= JERK_CAP;
		end else if ((st_q == ST_DIV) && div_sts.done) begin
			jerk_q <= (div_q > JERK_CAP) ? JERK_CAP : div_q;
		end
		if (st_q == ST_MUL3) begin
			acc_q <= mul_p[41:0];
		end
		if (st_q == ST_RAW) begin
			raw_mag_q <= (raw_mag_full[51:LIMIT_W] != '0) ? '1 : raw_mag_full[LIMIT_W-1:0];
			raw_neg_q <= dneg_q[axis_q] ^ !axis_q;
		end
		if (st_q == ST_MUL5) begin
			p1_q <= mul_p[47:0];
		end
		if ((st_q == ST_FIN) && out_free) begin
			m_tuser_q <= !yaw_bad_q;
			m_tdata_q <= {held_q[1], held_q[0], yaw_bad_q ? RATE_W'(0) : yaw_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	for (genvar i = 0; i < 2; i++) begin : g_held_ok
		assign held_ok[i] =
			($signed({held_q[i][RATE_W-1], held_q[i]}) <= $signed(cl_lim))
			&& ($signed({held_q[i][RATE_W-1], held_q[i]})
				>= $signed((RATE_W + 1)'(0) - cl_lim));
	end

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> (div_sts.busy || div_sts.done))
		else $error("divider idle while sequencer waits on it");

	a_jerk_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL2) |-> (jerk_q <= JERK_CAP))
		else $error("jerk above cap entering gain multiply");

	a_pitch_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_CLAMP) && !axis_q) |=> held_ok[0])
		else $error("pitch output outside rate limit");

	a_roll_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_CLAMP) && axis_q) |=> held_ok[1])
		else $error("roll output outside rate limit");

endmodule

>>> src/jprr_mul.sv
`timescale 1ns / 1ps
// shared unsigned 32x32 multiplier with registered product
module jprr_mul
	import jprr_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	logic [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

>>> src/jprr_div.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module jprr_div
	import jprr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IVAL_W-1:0]   rem_init,
	input  logic [JERK_W-1:0]   num,
	input  logic [IVAL_W-1:0]   den,
	output logic [JERK_W-1:0]   quo,
	output jprr_div_sts_t       sts
);

	logic [IVAL_W-1:0]    rem_q;
	logic [JERK_W-1:0]    quo_q;
	logic [IVAL_W-1:0]    den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [IVAL_W:0] trial;
	logic [IVAL_W:0] sub;
	logic            ge;

	assign trial = {rem_q, quo_q[JERK_W-1]};
	assign sub   = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(JERK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? sub[IVAL_W-1:0] : trial[IVAL_W-1:0];
			quo_q <= {quo_q[JERK_W-2:0], ge};
		end
	end

	assign quo      = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule
